>>> src/mpcbs_pkg.sv
// ----------------------------------------------------------------------------
// mpcbs_pkg
// Shared types, codes and arithmetic helpers of the bitrate selector.
// ----------------------------------------------------------------------------
`default_nettype none

package mpcbs_pkg;

   localparam int LEVELS_DEF      = 6;
   localparam int MAX_HORIZON_DEF = 5;
   localparam int MAX_CHUNKS_DEF  = 64;

   // upper limit of the horizon, fixes the width of the digit vector
   localparam int HORIZON_LIM = 5;

   localparam int QW     = 3;   // quality code width
   localparam int BUF_W  = 23;  // buffer level, seconds Q.16
   localparam int REB_W  = 35;  // rebuffer total, seconds Q.16
   localparam int KB_W   = 23;  // kbps / 1000 (Mbps), Q.16
   localparam int PEN_W  = 43;
   localparam int SUM_W  = 48;
   localparam int SEC_W  = 32;
   localparam int DEN_W  = 52;

   localparam logic [1:0] CMD_LOAD_SIZE    = 2'd0;
   localparam logic [1:0] CMD_LOAD_BITRATE = 2'd1;
   localparam logic [1:0] CMD_QUERY        = 2'd2;

   localparam logic [1:0] CSR_REBUF_PENALTY = 2'd0;
   localparam logic [1:0] CSR_BUFFER_WEIGHT = 2'd1;
   localparam logic [1:0] CSR_HORIZON       = 2'd2;
   localparam logic [1:0] CSR_VIDEO_CHUNKS  = 2'd3;

   localparam logic [15:0] REBUF_PENALTY_RST = 16'd1101;
   localparam logic [15:0] BUFFER_WEIGHT_RST = 16'd0;
   localparam logic [2:0]  HORIZON_RST       = 3'd5;
   localparam logic [6:0]  VIDEO_CHUNKS_RST  = 7'd48;

   localparam logic [SEC_W-1:0] RTT_Q16    = 32'd5243;
   localparam logic [BUF_W-1:0] REFILL_Q16 = 23'd262144;
   localparam logic signed [SUM_W-1:0] START_BEST = -48'sd6553600000000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_DIVIDE,
      ST_SCORE,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   // one quality sequence travelling down the scoring pipeline
   typedef struct packed {
      logic                            valid;
      logic                            last;
      logic [HORIZON_LIM-1:0][QW-1:0]  digits;
      logic [BUF_W-1:0]                buf_lvl;
      logic [REB_W-1:0]                rebuf;
      logic [15:0]                     br_prev;
      logic signed [SUM_W-1:0]         sum;
   } seq_type;

   // table writes broadcast to every stage
   typedef struct packed {
      logic             br_we;
      logic [QW-1:0]    br_addr;
      logic [15:0]      br_data;
      logic [KB_W-1:0]  kb_data;
      logic             d_we;
      logic [2:0]       d_pos;
      logic [QW-1:0]    d_q;
      logic [SEC_W-1:0] d_data;
   } tbl_wr_type;

   // floor(x / 125) for x below 2^29, by reciprocal multiply
   function automatic logic [KB_W-1:0] div125(input logic [28:0] x);
      logic [58:0] prod;
      prod = 59'(x) * 59'd549755814;
      return prod[58:36];
   endfunction

endpackage

`default_nettype wire

>>> src/mpcbs_div.sv
// ----------------------------------------------------------------------------
// mpcbs_div
// Bit-serial download time divider: size * 2^32 / den, saturated, plus rtt.
// ----------------------------------------------------------------------------
`default_nettype none

module mpcbs_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [25:0]                   size,
   input  wire logic [mpcbs_pkg::DEN_W-1:0]   den,
   output logic                               done,
   output logic [mpcbs_pkg::SEC_W-1:0]        quo
);

   logic [mpcbs_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [mpcbs_pkg::SEC_W-1:0] quo_ff, quo_in;
   logic                        sat_ff, sat_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [mpcbs_pkg::DEN_W:0]   rem2;
   logic [mpcbs_pkg::SEC_W:0]   sum_rtt;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem2    = {rem_ff, 1'b0};
      if (start) begin
         rem_in = mpcbs_pkg::DEN_W'(size);
         sat_in = (mpcbs_pkg::DEN_W'(size) >= den);
         quo_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem2 >= {1'b0, den}) begin
            rem_in = mpcbs_pkg::DEN_W'(rem2 - {1'b0, den});
            quo_in = {quo_ff[mpcbs_pkg::SEC_W-2:0], 1'b1};
         end else begin
            rem_in = rem2[mpcbs_pkg::DEN_W-1:0];
            quo_in = {quo_ff[mpcbs_pkg::SEC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
   end

   assign sum_rtt = {1'b0, quo_ff} + {1'b0, mpcbs_pkg::RTT_Q16};
   assign quo  = (sat_ff || sum_rtt[mpcbs_pkg::SEC_W]) ? '1 : sum_rtt[mpcbs_pkg::SEC_W-1:0];
   assign done = done_ff;

endmodule

`default_nettype wire

>>> src/mpcbs_stage.sv
// ----------------------------------------------------------------------------
// mpcbs_stage
// Three-stage pipeline segment scoring one chunk position of a sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module mpcbs_stage #(
   parameter int P      = 0,
   parameter int LEVELS = mpcbs_pkg::LEVELS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mpcbs_pkg::tbl_wr_type  tbl_wr,
   input  wire logic                   pos_active,
   input  wire logic [15:0]            rebuffer_penalty,
   input  wire logic [15:0]            buffer_weight,
   input  wire mpcbs_pkg::seq_type     seq_in,
   output mpcbs_pkg::seq_type          seq_out
);

   localparam int QIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   logic [mpcbs_pkg::SEC_W-1:0] d_ff  [LEVELS];
   logic [15:0]                 br_ff [8];
   logic [mpcbs_pkg::KB_W-1:0]  kb_ff [8];

   mpcbs_pkg::seq_type          s1_ff, s1_in, s2_ff, s3_ff, s3_in;
   logic [mpcbs_pkg::KB_W-1:0]  s1_kb_ff, s1_kb_in, s2_kb_ff;
   logic [15:0]                 s1_diff_ff, s1_diff_in;
   logic                        s1_act_ff, s2_act_ff;
   logic [mpcbs_pkg::KB_W-1:0]  s2_rdiff_ff;
   logic [mpcbs_pkg::PEN_W-1:0] s2_pen_ff, s2_pen_in;

   logic [mpcbs_pkg::QW-1:0]    q;
   logic [mpcbs_pkg::SEC_W-1:0] d;
   logic [15:0]                 br;
   logic [50:0]                 pen_prod;
   logic [38:0]                 wt_prod;
   logic signed [mpcbs_pkg::SUM_W-1:0] r;

   always_ff @(posedge clock) begin
      if (tbl_wr.d_we && tbl_wr.d_pos == 3'(P)) begin
         d_ff[tbl_wr.d_q[QIW-1:0]] <= tbl_wr.d_data;
      end
      if (tbl_wr.br_we) begin
         br_ff[tbl_wr.br_addr] <= tbl_wr.br_data;
         kb_ff[tbl_wr.br_addr] <= tbl_wr.kb_data;
      end
   end

   // stage 1: buffer simulation and table lookups
   always_comb begin
      q          = seq_in.digits[P];
      d          = d_ff[q[QIW-1:0]];
      br         = br_ff[q];
      s1_in      = seq_in;
      s1_kb_in   = kb_ff[q];
      s1_diff_in = (br >= seq_in.br_prev) ? br - seq_in.br_prev : seq_in.br_prev - br;
      if (pos_active) begin
         if (mpcbs_pkg::SEC_W'(seq_in.buf_lvl) < d) begin
            s1_in.rebuf   = seq_in.rebuf + mpcbs_pkg::REB_W'(d)
                            - mpcbs_pkg::REB_W'(seq_in.buf_lvl);
            s1_in.buf_lvl = mpcbs_pkg::REFILL_Q16;
         end else begin
            s1_in.buf_lvl = seq_in.buf_lvl - d[mpcbs_pkg::BUF_W-1:0]
                            + mpcbs_pkg::REFILL_Q16;
         end
         s1_in.br_prev = br;
      end
   end

   // stage 2: products
   assign pen_prod  = 51'(rebuffer_penalty) * 51'(s1_ff.rebuf);
   assign s2_pen_in = pen_prod[50:8];

   // stage 3: buffer term and accumulate
   assign wt_prod = 39'(buffer_weight) * 39'(s2_ff.buf_lvl);
   assign r = $signed({25'd0, s2_kb_ff}) - $signed({5'd0, s2_pen_ff})
              - $signed({25'd0, s2_rdiff_ff}) - $signed({25'd0, wt_prod[38:16]});
   always_comb begin
      s3_in = s2_ff;
      if (s2_act_ff) begin
         s3_in.sum = s2_ff.sum + r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s3_in;
      end
      s1_kb_ff    <= s1_kb_in;
      s1_diff_ff  <= s1_diff_in;
      s1_act_ff   <= pos_active;
      s2_kb_ff    <= s1_kb_ff;
      s2_act_ff   <= s1_act_ff;
      s2_rdiff_ff <= mpcbs_pkg::div125({s1_diff_ff, 13'd0});
      s2_pen_ff   <= s2_pen_in;
   end

   assign seq_out = s3_ff;

endmodule

`default_nettype wire

>>> src/mpc_bitrate_selector_core.sv
// ----------------------------------------------------------------------------
// mpc_bitrate_selector_core
// Model-predictive bitrate chooser with loadable chunk-size and bitrate tables.
// ----------------------------------------------------------------------------
// Items arrive on req_ (valid/ready): size loads, bitrate loads and queries.
// Loads give no result. A query returns one item on rsp_ with the best
// first quality and its reward. The user is to write registers on csr_
// only while the block is idle, which the block itself does not enforce;
// csr_ready is always high. A query first computes the download time of
// every quality at every planned position with a bit-serial divider, then
// streams LEVELS^h sequences, one per cycle, through a 3*MAX_HORIZON stage
// scoring pipeline and a compare stage. The divider and the sequence
// stream set the length of a query. One query is in work at a time;
// req_ready is high only between queries. A finished result waits in the
// rsp_ register while the next item is taken; a second query holds its
// result until the first is taken. Reset restores the register defaults;
// both tables hold no defined value until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_bitrate_selector_core #(
   parameter int LEVELS      = mpcbs_pkg::LEVELS_DEF,
   parameter int MAX_HORIZON = mpcbs_pkg::MAX_HORIZON_DEF,
   parameter int MAX_CHUNKS  = mpcbs_pkg::MAX_CHUNKS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [2:0]         req_quality_index,
   input  wire logic [5:0]         req_chunk_index,
   input  wire logic [25:0]        req_load_value,
   input  wire logic [2:0]         req_last_quality,
   input  wire logic [31:0]        req_predicted_throughput,
   input  wire logic [15:0]        req_buffer_level_ms,
   input  wire logic [5:0]         req_chunks_played,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_best_quality,
   output logic signed [47:0]      rsp_best_reward,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   localparam int AW = $clog2(8 * MAX_CHUNKS);
   localparam logic [AW-1:0] CHUNKS_AW = AW'(MAX_CHUNKS);
   localparam logic [2:0] QMAX = 3'(LEVELS - 1);

   mpcbs_pkg::state_type state_ff, state_in;

   logic [15:0] rebuffer_penalty_ff, buffer_weight_ff;
   logic [2:0]  horizon_ff;
   logic [6:0]  video_chunks_ff;

   logic [25:0] size_mem [8 * MAX_CHUNKS];
   logic [25:0] mem_q_ff;
   logic [15:0] br_main [8];

   logic [2:0]  h_ff, len_ff, p_cnt_ff, q_cnt_ff;
   logic [5:0]  played_ff;
   logic [mpcbs_pkg::DEN_W-1:0] den_ff;
   logic [mpcbs_pkg::BUF_W-1:0] start_buf_ff;
   logic [15:0] br_last_ff;
   logic [mpcbs_pkg::HORIZON_LIM-1:0][2:0] dig_ff, dig_in;

   logic signed [47:0] best_ff;
   logic [2:0]         bestq_ff;
   logic               done_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_q_ff;
   logic signed [47:0] rsp_r_ff;

   logic req_acc, query_acc, div_start, div_done, launch, rsp_load, d_write, seq_last;
   logic [mpcbs_pkg::SEC_W-1:0] div_quo;
   logic [2:0]  h_in, len_in;
   logic [6:0]  total;
   logic signed [7:0] left;
   logic [31:0] tput;
   logic [AW-1:0] rd_addr, wr_addr;
   logic carry;

   mpcbs_pkg::tbl_wr_type tbl_wr;
   mpcbs_pkg::seq_type    pipe [MAX_HORIZON + 1];

   assign req_ready = (state_ff == mpcbs_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && req_ready;
   assign query_acc = req_acc && (req_command == mpcbs_pkg::CMD_QUERY);

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rebuffer_penalty_ff <= mpcbs_pkg::REBUF_PENALTY_RST;
         buffer_weight_ff    <= mpcbs_pkg::BUFFER_WEIGHT_RST;
         horizon_ff          <= mpcbs_pkg::HORIZON_RST;
         video_chunks_ff     <= mpcbs_pkg::VIDEO_CHUNKS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            mpcbs_pkg::CSR_REBUF_PENALTY: rebuffer_penalty_ff <= csr_data;
            mpcbs_pkg::CSR_BUFFER_WEIGHT: buffer_weight_ff    <= csr_data;
            mpcbs_pkg::CSR_HORIZON:       horizon_ff          <= csr_data[2:0];
            mpcbs_pkg::CSR_VIDEO_CHUNKS:  video_chunks_ff     <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // query setup
   always_comb begin
      if (horizon_ff == 3'd0) begin
         h_in = 3'd1;
      end else if (horizon_ff > 3'(MAX_HORIZON)) begin
         h_in = 3'(MAX_HORIZON);
      end else begin
         h_in = horizon_ff;
      end
      total = (video_chunks_ff > 7'(MAX_CHUNKS)) ? 7'(MAX_CHUNKS) : video_chunks_ff;
      left  = $signed({1'b0, total}) - $signed({2'b0, req_chunks_played});
      if (left <= 8'sd0) begin
         len_in = 3'd0;
      end else if (left > $signed({5'd0, h_in})) begin
         len_in = h_in;
      end else begin
         len_in = left[2:0];
      end
      tput = (req_predicted_throughput == 32'd0) ? 32'd1 : req_predicted_throughput;
   end

   // tables
   assign wr_addr = AW'(req_quality_index) * CHUNKS_AW + AW'(req_chunk_index);
   assign rd_addr = AW'(q_cnt_ff) * CHUNKS_AW + AW'(played_ff) + AW'(p_cnt_ff);

   always_ff @(posedge clock) begin
      if (req_acc && req_command == mpcbs_pkg::CMD_LOAD_SIZE
          && {1'b0, req_chunk_index} < 7'(MAX_CHUNKS)) begin
         size_mem[wr_addr] <= req_load_value;
      end
      mem_q_ff <= size_mem[rd_addr];
      if (tbl_wr.br_we) begin
         br_main[req_quality_index] <= req_load_value[15:0];
      end
   end

   always_comb begin
      tbl_wr.br_we   = req_acc && (req_command == mpcbs_pkg::CMD_LOAD_BITRATE);
      tbl_wr.br_addr = req_quality_index;
      tbl_wr.br_data = req_load_value[15:0];
      tbl_wr.kb_data = mpcbs_pkg::div125({req_load_value[15:0], 13'd0});
      tbl_wr.d_we    = d_write;
      tbl_wr.d_pos   = p_cnt_ff;
      tbl_wr.d_q     = q_cnt_ff;
      tbl_wr.d_data  = div_quo;
   end

   mpcbs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .size  (mem_q_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   // sequence odometer, digit 0 least significant
   always_comb begin
      dig_in   = dig_ff;
      carry    = 1'b1;
      seq_last = 1'b1;
      for (int p = 0; p < MAX_HORIZON; p++) begin
         if (3'(p) < h_ff) begin
            if (dig_ff[p] != QMAX) begin
               seq_last = 1'b0;
            end
            if (carry) begin
               if (dig_ff[p] == QMAX) begin
                  dig_in[p] = 3'd0;
               end else begin
                  dig_in[p] = dig_ff[p] + 3'd1;
                  carry     = 1'b0;
               end
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpcbs_pkg::ST_IDLE: begin
            if (query_acc) begin
               state_in = (len_in == 3'd0) ? mpcbs_pkg::ST_SCORE : mpcbs_pkg::ST_FETCH;
            end
         end
         mpcbs_pkg::ST_FETCH:  state_in = mpcbs_pkg::ST_LOAD;
         mpcbs_pkg::ST_LOAD:   state_in = mpcbs_pkg::ST_DIVIDE;
         mpcbs_pkg::ST_DIVIDE: begin
            if (div_done) begin
               if (q_cnt_ff == QMAX && p_cnt_ff == len_ff - 3'd1) begin
                  state_in = mpcbs_pkg::ST_SCORE;
               end else begin
                  state_in = mpcbs_pkg::ST_FETCH;
               end
            end
         end
         mpcbs_pkg::ST_SCORE: begin
            if (seq_last) begin
               state_in = mpcbs_pkg::ST_DRAIN;
            end
         end
         mpcbs_pkg::ST_DRAIN: begin
            if (done_ff) begin
               state_in = mpcbs_pkg::ST_HOLD;
            end
         end
         mpcbs_pkg::ST_HOLD: begin
            if (rsp_load) begin
               state_in = mpcbs_pkg::ST_IDLE;
            end
         end
         default: state_in = mpcbs_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      div_start = (state_ff == mpcbs_pkg::ST_LOAD);
      d_write   = (state_ff == mpcbs_pkg::ST_DIVIDE) && div_done;
      launch    = (state_ff == mpcbs_pkg::ST_SCORE);
      rsp_load  = (state_ff == mpcbs_pkg::ST_HOLD) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpcbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (query_acc) begin
         h_ff         <= h_in;
         len_ff       <= len_in;
         played_ff    <= req_chunks_played;
         den_ff       <= mpcbs_pkg::DEN_W'(tput) * mpcbs_pkg::DEN_W'(20'd1000000);
         start_buf_ff <= mpcbs_pkg::div125({req_buffer_level_ms, 13'd0});
         br_last_ff   <= br_main[req_last_quality];
         p_cnt_ff     <= 3'd0;
         q_cnt_ff     <= 3'd0;
         dig_ff       <= '0;
      end else begin
         if (d_write) begin
            if (q_cnt_ff == QMAX) begin
               q_cnt_ff <= 3'd0;
               p_cnt_ff <= p_cnt_ff + 3'd1;
            end else begin
               q_cnt_ff <= q_cnt_ff + 3'd1;
            end
         end
         if (launch) begin
            dig_ff <= dig_in;
         end
      end
   end

   // scoring pipeline
   always_comb begin
      pipe[0].valid   = launch;
      pipe[0].last    = seq_last;
      pipe[0].digits  = dig_ff;
      pipe[0].buf_lvl = start_buf_ff;
      pipe[0].rebuf   = '0;
      pipe[0].br_prev = br_last_ff;
      pipe[0].sum     = '0;
   end

   for (genvar g = 0; g < MAX_HORIZON; g++) begin : g_stage
      mpcbs_stage #(
         .P      (g),
         .LEVELS (LEVELS)
      ) u_stage (
         .clock            (clock),
         .reset            (reset),
         .tbl_wr           (tbl_wr),
         .pos_active       (3'(g) < len_ff),
         .rebuffer_penalty (rebuffer_penalty_ff),
         .buffer_weight    (buffer_weight_ff),
         .seq_in           (pipe[g]),
         .seq_out          (pipe[g + 1])
      );
   end

   // best tracking, ties go to the later sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= pipe[MAX_HORIZON].valid && pipe[MAX_HORIZON].last;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (query_acc) begin
         best_ff  <= mpcbs_pkg::START_BEST;
         bestq_ff <= 3'd0;
      end else if (pipe[MAX_HORIZON].valid && pipe[MAX_HORIZON].sum >= best_ff) begin
         best_ff  <= pipe[MAX_HORIZON].sum;
         bestq_ff <= pipe[MAX_HORIZON].digits[0];
      end
      if (rsp_load) begin
         rsp_q_ff <= bestq_ff;
         rsp_r_ff <= best_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_quality = rsp_q_ff;
   assign rsp_best_reward  = rsp_r_ff;

   a_div_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == mpcbs_pkg::ST_DIVIDE)
      else $error("divider finished outside the divide phase");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == mpcbs_pkg::ST_DRAIN)
      else $error("last sequence arrived outside the drain phase");

   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      pipe[MAX_HORIZON].valid
      |-> (state_ff == mpcbs_pkg::ST_SCORE || state_ff == mpcbs_pkg::ST_DRAIN))
      else $error("scored item outside a query");

endmodule

`default_nettype wire
